FILE: rtl/cit_pkg.sv
package cit_pkg;

    localparam int FUNC_W  = 3;
    localparam int OWNER_W = 8;
    localparam int KEY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 7;
    localparam int ENTRY_W = OWNER_W + KEY_W;

    localparam int ENTRIES_DEFAULT = 128;

    localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FIND_KEY = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FIND_ID  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXISTS    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [OWNER_W-1:0] owner_id;
        logic [KEY_W-1:0]   card_key;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OWNER_W-1:0] found_id;
        logic [KEY_W-1:0]   found_key;
        logic [SLOT_W-1:0]  slot;
    } rsp_t;

endpackage

FILE: rtl/card_id_table_unit.sv
// card id table: ENTRIES entries of owner id and card key, kept in one
// simple dual-port ram with a registered read
// command channel: cmd is taken at a rising edge with start high and busy
// low; busy stays high while an operation or a clearing pass runs
// result channel: each result shows on rsp for exactly one cycle with done
// high; the receiver takes it at the end of that cycle and cannot stall it
// insert, find by key, find by id and delete scan the entries in index
// order, one ram read per cycle; a hit at entry i gives done in the
// cycle i + 3 after the transfer, a miss in the cycle ENTRIES + 2
// clear all writes zero to one entry per cycle, ENTRIES cycles, and done
// comes in the cycle ENTRIES + 1 after the transfer
// unused func codes give done with status not found in the next cycle
// a new command may be taken in the cycle that done is high
// reset starts a clearing pass of ENTRIES cycles with busy high and no
// result; the table reads all zero after it
module card_id_table_unit #(
    parameter int ENTRIES = cit_pkg::ENTRIES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cit_pkg::cmd_t cmd,
    output logic          done,
    output cit_pkg::rsp_t rsp
);

    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CntW = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [IdxW-1:0]       cmp_reg, cmp_next;
    logic                  dvalid_reg, dvalid_next;
    logic                  report_reg, report_next;
    logic                  done_reg, done_next;
    cit_pkg::cmd_t         op_reg, op_next;
    cit_pkg::rsp_t         rsp_reg, rsp_next;

    logic                        ram_we;
    logic [IdxW-1:0]             ram_waddr;
    logic [cit_pkg::ENTRY_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [cit_pkg::ENTRY_W-1:0] ram_rdata;

    logic [cit_pkg::OWNER_W-1:0] e_owner;
    logic [cit_pkg::KEY_W-1:0]   e_key;
    logic                        id_hit;
    logic                        key_hit;
    logic                        empty_hit;

    cit_ram #(
        .WIDTH (cit_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[IdxW-1:0]),
        .rdata (ram_rdata)
    );

    assign e_owner   = ram_rdata[cit_pkg::ENTRY_W-1:cit_pkg::KEY_W];
    assign e_key     = ram_rdata[cit_pkg::KEY_W-1:0];
    assign id_hit    = (e_owner == op_reg.owner_id);
    assign key_hit   = (e_key == op_reg.card_key);
    assign empty_hit = (e_key[7:0] == 8'h00);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmp_next    = cmp_reg;
        dvalid_next = 1'b0;
        report_next = report_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        rsp_next    = rsp_reg;
        ram_we      = 1'b0;
        ram_waddr   = cmp_reg;
        ram_wdata   = '0;
        ram_re      = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[IdxW-1:0];
                if (cnt_reg == CntW'(ENTRIES - 1))
                begin
                    state_next  = S_IDLE;
                    report_next = 1'b0;
                    if (report_reg)
                    begin
                        done_next       = 1'b1;
                        rsp_next        = '0;
                        rsp_next.status = cit_pkg::ST_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CntW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd;
                    cnt_next = '0;
                    if (cmd.func == cit_pkg::FN_CLEAR)
                    begin
                        state_next  = S_CLR;
                        report_next = 1'b1;
                    end
                    else if (cmd.func == cit_pkg::FN_INSERT ||
                             cmd.func == cit_pkg::FN_FIND_KEY ||
                             cmd.func == cit_pkg::FN_FIND_ID ||
                             cmd.func == cit_pkg::FN_DELETE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        rsp_next        = '0;
                        rsp_next.status = cit_pkg::ST_NOT_FOUND;
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg < CntW'(ENTRIES))
                begin
                    ram_re      = 1'b1;
                    dvalid_next = 1'b1;
                    cmp_next    = cnt_reg[IdxW-1:0];
                    cnt_next    = cnt_reg + CntW'(1);
                end
                if (dvalid_reg)
                begin
                    rsp_next      = '0;
                    rsp_next.slot = cit_pkg::SLOT_W'(cmp_reg);
                    case (op_reg.func)
                        cit_pkg::FN_INSERT:
                        begin
                            if (id_hit)
                            begin
                                rsp_next.status = cit_pkg::ST_EXISTS;
                                done_next       = 1'b1;
                            end
                            else if (empty_hit)
                            begin
                                rsp_next.status = cit_pkg::ST_DONE;
                                ram_we          = 1'b1;
                                ram_wdata       = {op_reg.owner_id, op_reg.card_key};
                                done_next       = 1'b1;
                            end
                        end
                        cit_pkg::FN_FIND_KEY:
                        begin
                            if (key_hit)
                            begin
                                rsp_next.status   = cit_pkg::ST_DONE;
                                rsp_next.found_id = e_owner;
                                done_next         = 1'b1;
                            end
                        end
                        cit_pkg::FN_FIND_ID:
                        begin
                            if (id_hit)
                            begin
                                rsp_next.status    = cit_pkg::ST_DONE;
                                rsp_next.found_key = e_key;
                                done_next          = 1'b1;
                            end
                        end
                        cit_pkg::FN_DELETE:
                        begin
                            if (id_hit || key_hit)
                            begin
                                rsp_next.status = cit_pkg::ST_DONE;
                                ram_we          = 1'b1;
                                done_next       = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (!done_next && cmp_reg == IdxW'(ENTRIES - 1))
                    begin
                        done_next       = 1'b1;
                        rsp_next        = '0;
                        rsp_next.status = (op_reg.func == cit_pkg::FN_INSERT) ?
                                          cit_pkg::ST_FULL : cit_pkg::ST_NOT_FOUND;
                    end
                    if (done_next)
                    begin
                        state_next  = S_IDLE;
                        dvalid_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cnt_reg    <= '0;
            cmp_reg    <= '0;
            dvalid_reg <= 1'b0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cmp_reg    <= cmp_next;
            dvalid_reg <= dvalid_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_clear_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func == cit_pkg::FN_CLEAR) |=> busy)
        else $error("clear transfer did not start a clearing pass");

    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLR || dvalid_reg))
        else $error("ram write outside clear or entry compare");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (state_reg == S_SCAN && cnt_reg < CntW'(ENTRIES)))
        else $error("ram read beyond the table");

    a_compare_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dvalid_reg |-> (state_reg == S_SCAN))
        else $error("entry compare outside a scan");

endmodule

FILE: rtl/cit_ram.sv
module cit_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: tb/sv/card_id_table_unit_tb.sv
`timescale 1ns / 100ps

module card_id_table_unit_tb;

    import cit_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEFAULT;
    localparam int STALL_LIMIT = 20 * ENTRIES;

    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    rsp_t rsp;

    logic [OWNER_W-1:0] owner_tab [ENTRIES];
    logic [KEY_W-1:0]   key_tab   [ENTRIES];

    rsp_t expected_rsp [$];
    int   err_count;
    int   stall_cycles;
    bit   gaps_on;

    card_id_table_unit #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .cmd  (cmd),
        .done (done),
        .rsp  (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // table model: applies one command and returns the result it gives
    function automatic rsp_t run_table_op(input cmd_t c);
        rsp_t r;
        bit   hit;
        r        = '0;
        r.status = ST_NOT_FOUND;
        hit      = 1'b0;
        case (c.func)
            FN_INSERT:
            begin
                r.status = ST_FULL;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!hit && owner_tab[i] == c.owner_id)
                    begin
                        r.status = ST_EXISTS;
                        r.slot   = SLOT_W'(i);
                        hit      = 1'b1;
                    end
                    else if (!hit && key_tab[i][7:0] == 8'h00)
                    begin
                        owner_tab[i] = c.owner_id;
                        key_tab[i]   = c.card_key;
                        r.status     = ST_DONE;
                        r.slot       = SLOT_W'(i);
                        hit          = 1'b1;
                    end
                end
            end
            FN_FIND_KEY:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!hit && key_tab[i] == c.card_key)
                    begin
                        r.status   = ST_DONE;
                        r.found_id = owner_tab[i];
                        r.slot     = SLOT_W'(i);
                        hit        = 1'b1;
                    end
                end
            end
            FN_FIND_ID:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!hit && owner_tab[i] == c.owner_id)
                    begin
                        r.status    = ST_DONE;
                        r.found_key = key_tab[i];
                        r.slot      = SLOT_W'(i);
                        hit         = 1'b1;
                    end
                end
            end
            FN_DELETE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!hit && (owner_tab[i] == c.owner_id || key_tab[i] == c.card_key))
                    begin
                        owner_tab[i] = '0;
                        key_tab[i]   = '0;
                        r.status     = ST_DONE;
                        r.slot       = SLOT_W'(i);
                        hit          = 1'b1;
                    end
                end
            end
            FN_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    owner_tab[i] = '0;
                    key_tab[i]   = '0;
                end
                r.status = ST_DONE;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t mk_cmd(input logic [FUNC_W-1:0] f,
                                    input logic [OWNER_W-1:0] id,
                                    input logic [KEY_W-1:0] key);
        cmd_t c;
        c.func     = f;
        c.owner_id = id;
        c.card_key = key;
        return c;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [OWNER_W-1:0] pick_owner();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return owner_tab[$urandom_range(0, ENTRIES - 1)];
        if (r < 50)
            return '0;
        return OWNER_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return key_tab[$urandom_range(0, ENTRIES - 1)];
        if (r < 48)
            return '0;
        return $urandom;
    endfunction

    function automatic cmd_t random_cmd(input int ins_pct);
        cmd_t c;
        int   r;
        c.owner_id = pick_owner();
        c.card_key = pick_key();
        r          = $urandom_range(0, 99);
        if (r < ins_pct)
        begin
            c.func = FN_INSERT;
            if ($urandom_range(0, 99) < 8)
                c.card_key[7:0] = 8'h00;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                c.func = FN_FIND_KEY;
            else if (r < 60)
                c.func = FN_FIND_ID;
            else if (r < 90)
                c.func = FN_DELETE;
            else if (r < 92)
                c.func = FN_CLEAR;
            else
                c.func = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] got,
                               input logic [KEY_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // one command transfer; expectation is recorded at the accepting edge
    task automatic send_cmd(input cmd_t c);
        int gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_rsp.push_back(run_table_op(c));
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n === 1'b1)
        begin
            if ($isunknown(done))
                report_mismatch("done is unknown");
            else if (done)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("status", KEY_W'(rsp.status), KEY_W'(want.status));
                    check_field("found_id", KEY_W'(rsp.found_id), KEY_W'(want.found_id));
                    check_field("found_key", rsp.found_key, want.found_key);
                    check_field("slot", KEY_W'(rsp.slot), KEY_W'(want.slot));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (start && busy === 1'b0) || done === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic test_empty_table();
        send_cmd(mk_cmd(FN_FIND_KEY, 8'h00, 32'h0000_0000));
        send_cmd(mk_cmd(FN_FIND_ID, 8'h00, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(FN_INSERT, 8'h00, 32'h0000_00A5));
        send_cmd(mk_cmd(FN_DELETE, 8'h00, 32'h1111_1111));
        send_cmd(mk_cmd(FN_FIND_KEY, 8'hFF, 32'hFFFF_FFFF));
        wait_all_results();
    endtask

    task automatic test_insert_find_delete();
        send_cmd(mk_cmd(FN_INSERT, 8'hFF, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(FN_INSERT, 8'h01, 32'h0000_0001));
        send_cmd(mk_cmd(FN_INSERT, 8'hFF, 32'h0000_0077));
        // key byte 0 zero: stored, but the entry still reads as free
        send_cmd(mk_cmd(FN_INSERT, 8'h5A, 32'h1234_5600));
        send_cmd(mk_cmd(FN_FIND_ID, 8'h5A, 32'h0000_0000));
        send_cmd(mk_cmd(FN_INSERT, 8'h3C, 32'h8000_0081));
        send_cmd(mk_cmd(FN_FIND_KEY, 8'h00, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(FN_FIND_ID, 8'h01, 32'h0000_0000));
        send_cmd(mk_cmd(FN_FIND_ID, 8'h77, 32'h0000_0000));
        send_cmd(mk_cmd(FN_DELETE, 8'h99, 32'h0000_0001));
        send_cmd(mk_cmd(FN_DELETE, 8'hFF, 32'h5555_AAAA));
        send_cmd(mk_cmd(FN_DELETE, 8'h42, 32'hDEAD_BEEF));
        wait_all_results();
    endtask

    task automatic test_spare_codes();
        send_cmd(mk_cmd(FN_SPARE_FIRST, 8'hFF, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(FN_SPARE_MID, 8'h3C, 32'h8000_0081));
        send_cmd(mk_cmd(FN_SPARE_LAST, 8'h00, 32'h0000_0000));
        wait_all_results();
    endtask

    task automatic test_clear_all();
        send_cmd(mk_cmd(FN_CLEAR, 8'h3C, 32'h8000_0081));
        send_cmd(mk_cmd(FN_FIND_ID, 8'h3C, 32'h0000_0000));
        wait_all_results();
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] key;
        send_cmd(mk_cmd(FN_CLEAR, 8'h00, 32'h0000_0000));
        for (int k = 1; k <= ENTRIES; k++)
        begin
            key = $urandom;
            if (key[7:0] == 8'h00)
                key[7:0] = 8'h01;
            send_cmd(mk_cmd(FN_INSERT, OWNER_W'(k), key));
        end
        send_cmd(mk_cmd(FN_INSERT, 8'hC8, 32'h0000_0042));
        send_cmd(mk_cmd(FN_INSERT, 8'h00, 32'h0000_0042));
        send_cmd(mk_cmd(FN_INSERT, OWNER_W'(ENTRIES), 32'h0000_0042));
        send_cmd(mk_cmd(FN_FIND_ID, OWNER_W'(ENTRIES), 32'h0000_0000));
        send_cmd(mk_cmd(FN_FIND_KEY, 8'h00, key_tab[ENTRIES - 1]));
        send_cmd(mk_cmd(FN_DELETE, OWNER_W'(ENTRIES / 2), 32'h0000_0000));
        send_cmd(mk_cmd(FN_INSERT, 8'hC9, 32'hCAFE_F00D));
        send_cmd(mk_cmd(FN_INSERT, 8'hCA, 32'hCAFE_F00E));
        wait_all_results();
    endtask

    task automatic test_random_mix();
        int ins_pct [5];
        ins_pct = '{70, 35, 20, 50, 10};
        for (int p = 0; p < 5; p++)
        begin
            gaps_on = (p != 0 && p != 2);
            for (int n = 0; n < 220; n++)
                send_cmd(random_cmd(ins_pct[p]));
            wait_all_results();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        err_count = 0;
        gaps_on   = 1'b1;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            owner_tab[i] = '0;
            key_tab[i]   = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_insert_find_delete();
        test_spare_codes();
        test_clear_all();
        test_table_full();
        test_random_mix();

        wait_all_results();
        repeat (ENTRIES + 8) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
